[hdl/s20_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s20_pkg: shared definitions for the Salsa20 stream cipher
// Constants, register indexes, state encodings and the control structs
// passed between the top level and the block generator.
// ----------------------------------------------------------------------------
package s20_pkg;

	localparam int ROUND_COUNT   = 20;
	// rounds go in column/row pairs; an odd count rounds up
	localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
	// one half quarter-round per cycle, 8 quarter-rounds per double round
	localparam int ROUND_STEPS   = DOUBLE_ROUNDS * 16;
	localparam int STEP_W        = $clog2(ROUND_STEPS);

	localparam int CFG_IDX_W = 3;

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE      = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GEN,
		ST_XFORM
	} top_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ROUND,
		CS_ADD
	} core_state_t;

	typedef struct packed {
		logic start;
	} s20_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} s20_sts_t;

endpackage

[hdl/salsa20_stream_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salsa20_stream_cipher: byte-wide Salsa20 encrypt/decrypt
// XORs each stream byte with the Salsa20 keystream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one byte per beat; s_tlast ends a message and drops
//   the rest of the current keystream block. m_* returns the XORed byte.
//   cfg_* writes a 64-bit register: index 0..3 key parts (key bytes 0..31,
//   little-endian), index 4 nonce. A nonce write clears the block counter
//   and drops the buffered block. Other indexes are ignored. Configure only
//   while no byte is in flight.
// Flow:
//   With a keystream block on hand a byte is accepted in ST_IDLE, then
//   ST_XFORM XORs it with the keystream byte into the output register.
//   When a new block is needed, ST_GEN waits for the generator, which runs
//   half a quarter-round per cycle in the shared unit for ceil(ROUND_COUNT/2)
//   double rounds, then one feed-forward add per word.
// Reset / stall:
//   arst_n clears key, nonce, counter and drops any block. The output
//   register holds its beat while m_tready is low; one more byte may be
//   accepted and waits in the XOR stage until the output frees up.
// ----------------------------------------------------------------------------
module salsa20_stream_cipher import s20_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 s_tlast,   // last_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] out_byte
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	top_state_t  st_q, st_d;
	s20_ctl_t    ctl;
	s20_sts_t    sts;

	logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_q;
	logic [63:0] ctr_q;
	logic [5:0]  pos_q;
	logic        blk_valid_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        m_valid_q;
	logic [7:0]  m_data_q;
	logic [7:0]  ks_byte;
	logic        in_fire, out_load, cfg_fire;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign in_fire   = s_tvalid & s_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	s20_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.key_part_0 (key0_q),
		.key_part_1 (key1_q),
		.key_part_2 (key2_q),
		.key_part_3 (key3_q),
		.nonce      (nonce_q),
		.counter    (ctr_q),
		.pos        (pos_q),
		.ks_byte    (ks_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// sequencer: accept, optional block generation, XOR into output register
	always_comb begin
		st_d      = st_q;
		s_tready  = 1'b0;
		ctl.start = 1'b0;
		out_load  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (blk_valid_q) begin
						st_d = ST_XFORM;
					end else begin
						st_d      = ST_GEN;
						ctl.start = 1'b1;
					end
				end
			end
			ST_GEN: begin
				if (sts.done) begin
					st_d = ST_XFORM;
				end
			end
			ST_XFORM: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// input byte holding register and XOR into the output register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q <= s_tdata;
			last_q <= s_tlast;
		end
		if (out_load) begin
			m_data_q <= data_q ^ ks_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// block bookkeeping and configuration; config writes win (last assignment)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q      <= '0;
			key1_q      <= '0;
			key2_q      <= '0;
			key3_q      <= '0;
			nonce_q     <= '0;
			ctr_q       <= '0;
			pos_q       <= '0;
			blk_valid_q <= 1'b0;
		end else begin
			if (sts.done) begin
				blk_valid_q <= 1'b1;
				pos_q       <= '0;
				ctr_q       <= ctr_q + 64'd1;
			end
			if (out_load) begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					blk_valid_q <= 1'b0;
				end
				if (last_q) begin
					// end of message drops what is left of the block
					blk_valid_q <= 1'b0;
					pos_q       <= '0;
				end
			end
			if (cfg_fire) begin
				unique case (cfg_index)
					REG_KEY_PART_0: key0_q <= cfg_data;
					REG_KEY_PART_1: key1_q <= cfg_data;
					REG_KEY_PART_2: key2_q <= cfg_data;
					REG_KEY_PART_3: key3_q <= cfg_data;
					REG_NONCE: begin
						nonce_q     <= cfg_data;
						ctr_q       <= '0;
						blk_valid_q <= 1'b0;
						pos_q       <= '0;
					end
					default: ;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_done_in_gen: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (st_q == ST_GEN))
		else $error("keystream done outside generation");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> sts.busy)
		else $error("generator did not start");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !s_tready)
		else $error("byte accepted during block generation");

	a_nonce_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_fire && (cfg_index == REG_NONCE)) |=>
		((ctr_q == 64'd0) && !blk_valid_q && (pos_q == 6'd0)))
		else $error("nonce write did not reset block state");
`endif

endmodule

[hdl/s20_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s20_core: Salsa20 keystream block generator
// One shared half quarter-round unit on fixed positions, with a diagonal
// state rotation after each quarter-round, then a serial feed-forward add.
// ----------------------------------------------------------------------------
module s20_core import s20_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  s20_ctl_t    ctl,
	output s20_sts_t    sts,
	input  logic [63:0] key_part_0,
	input  logic [63:0] key_part_1,
	input  logic [63:0] key_part_2,
	input  logic [63:0] key_part_3,
	input  logic [63:0] nonce,
	input  logic [63:0] counter,
	input  logic [5:0]  pos,
	output logic [7:0]  ks_byte
);

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	core_state_t       st_q, st_d;
	logic [STEP_W-1:0] step_q;
	logic [3:0]        add_q;
	logic [31:0]       w_q [16];
	logic [31:0]       in_w [16];
	logic [31:0]       upd [16];
	logic [31:0]       sft [16];
	logic [31:0]       wa, wb, wc, wd;
	logic [31:0]       sum0, sum1, x0, x1;
	logic [31:0]       na, nb, nc, nd;
	logic              row, half, last_step, last_add;

	assign in_w[0]  = SIGMA_0;
	assign in_w[1]  = key_part_0[31:0];
	assign in_w[2]  = key_part_0[63:32];
	assign in_w[3]  = key_part_1[31:0];
	assign in_w[4]  = key_part_1[63:32];
	assign in_w[5]  = SIGMA_1;
	assign in_w[6]  = nonce[31:0];
	assign in_w[7]  = nonce[63:32];
	assign in_w[8]  = counter[31:0];
	assign in_w[9]  = counter[63:32];
	assign in_w[10] = SIGMA_2;
	assign in_w[11] = key_part_2[31:0];
	assign in_w[12] = key_part_2[63:32];
	assign in_w[13] = key_part_3[31:0];
	assign in_w[14] = key_part_3[63:32];
	assign in_w[15] = SIGMA_3;

	// step bit 0: which half of the quarter-round; bit 3: row round
	assign half      = step_q[0];
	assign row       = step_q[3];
	assign last_step = (step_q == STEP_W'(ROUND_STEPS - 1));
	assign last_add  = (add_q == 4'd15);

	// quarter-round always works on column 0 or row 0
	always_comb begin
		wa = w_q[0];
		wb = row ? w_q[1] : w_q[4];
		wc = row ? w_q[2] : w_q[8];
		wd = row ? w_q[3] : w_q[12];

		sum0 = half ? (wc + wb) : (wa + wd);
		x0   = (half ? wd : wb) ^ (half ? rotl(sum0, 13) : rotl(sum0, 7));
		sum1 = half ? (x0 + wc) : (x0 + wa);
		x1   = (half ? wa : wc) ^ (half ? rotl(sum1, 18) : rotl(sum1, 9));

		nb = half ? wb : x0;
		nc = half ? wc : x1;
		nd = half ? x0 : wd;
		na = half ? x1 : wa;

		upd    = w_q;
		upd[0] = na;
		if (row) begin
			upd[1] = nb;
			upd[2] = nc;
			upd[3] = nd;
		end else begin
			upd[4]  = nb;
			upd[8]  = nc;
			upd[12] = nd;
		end

		// diagonal shift brings the next quarter-round to column/row 0
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				sft[4 * r + c] = upd[4 * ((r + 1) % 4) + ((c + 1) % 4)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CS_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		sts.busy = (st_q != CS_IDLE);
		sts.done = 1'b0;
		unique case (st_q)
			CS_IDLE: begin
				if (ctl.start) begin
					st_d = CS_ROUND;
				end
			end
			CS_ROUND: begin
				if (last_step) begin
					st_d = CS_ADD;
				end
			end
			CS_ADD: begin
				if (last_add) begin
					st_d     = CS_IDLE;
					sts.done = 1'b1;
				end
			end
			default: st_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			add_q  <= '0;
		end else begin
			if (st_q == CS_IDLE) begin
				step_q <= '0;
				add_q  <= '0;
			end else if (st_q == CS_ROUND) begin
				step_q <= step_q + 1'b1;
			end else begin
				add_q <= add_q + 1'b1;
			end
		end
	end

	// keystream words, no reset
	always_ff @(posedge clk) begin
		unique case (st_q)
			CS_IDLE: begin
				if (ctl.start) begin
					w_q <= in_w;
				end
			end
			CS_ROUND: begin
				if (half) begin
					w_q <= sft;
				end else begin
					w_q <= upd;
				end
			end
			CS_ADD: begin
				// word add_q sits at 0; rotate down one, summed word at 15
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[15] <= w_q[0] + in_w[add_q];
			end
			default: ;
		endcase
	end

	assign ks_byte = w_q[pos[5:2]][{pos[1:0], 3'b000} +: 8];

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for salsa20_stream_cipher
// Sends byte messages through the cipher with random source gaps and sink
// stalls. A behavioral Salsa20 keystream generator predicts every output byte,
// and the bench checks each output in order. Key and nonce are rewritten
// between phases while the cipher is idle: extremes, ignored indexes, a key
// change over a buffered block, and a nonce change that drops it.
// ----------------------------------------------------------------------------
module testbench;
	import s20_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} plain_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;     // [7:0] data_byte
	logic                 s_tlast = 1'b0;   // last_byte
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;          // [7:0] out_byte
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;

	salsa20_stream_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #1 clk = ~clk;

	// Keystream state mirrored from the cipher
	logic [63:0] key_reg [4];
	logic [63:0] nonce_reg;
	logic [63:0] block_ctr;
	logic [31:0] ks_words [16];
	logic [5:0]  ks_pos;
	bit          ks_ready;
	logic [31:0] mix_w [16];     // scratch for the round function

	plain_beat_t plain_beats [$];        // bytes still to send
	logic [7:0]  cipher_bytes_due [$];   // predicted output bytes, oldest first
	int unsigned fault_count = 0;

	bit          send_calm = 1'b0;       // no gaps while set
	bit          recv_calm = 1'b0;       // no stalls while set
	logic [3:0]  send_wait = '0;
	logic [3:0]  recv_wait = '0;

	function automatic logic [31:0] rotl32(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void quarter_round(int a, int b, int c, int d);
		mix_w[b] ^= rotl32(mix_w[a] + mix_w[d], 7);
		mix_w[c] ^= rotl32(mix_w[b] + mix_w[a], 9);
		mix_w[d] ^= rotl32(mix_w[c] + mix_w[b], 13);
		mix_w[a] ^= rotl32(mix_w[d] + mix_w[c], 18);
	endfunction

	// Next 64-byte block from key, nonce and counter; counter then advances.
	function automatic void refill_keystream();
		logic [31:0] seed [16];
		seed[0]  = SIGMA_0;
		seed[5]  = SIGMA_1;
		seed[10] = SIGMA_2;
		seed[15] = SIGMA_3;
		seed[1]  = key_reg[0][31:0];
		seed[2]  = key_reg[0][63:32];
		seed[3]  = key_reg[1][31:0];
		seed[4]  = key_reg[1][63:32];
		seed[11] = key_reg[2][31:0];
		seed[12] = key_reg[2][63:32];
		seed[13] = key_reg[3][31:0];
		seed[14] = key_reg[3][63:32];
		seed[6]  = nonce_reg[31:0];
		seed[7]  = nonce_reg[63:32];
		seed[8]  = block_ctr[31:0];
		seed[9]  = block_ctr[63:32];
		for (int i = 0; i < 16; i++)
			mix_w[i] = seed[i];
		// column round then row round; odd counts round up
		for (int r = ROUND_COUNT; r > 0; r -= 2) begin
			quarter_round(0, 4, 8, 12);
			quarter_round(5, 9, 13, 1);
			quarter_round(10, 14, 2, 6);
			quarter_round(15, 3, 7, 11);
			quarter_round(0, 1, 2, 3);
			quarter_round(5, 6, 7, 4);
			quarter_round(10, 11, 8, 9);
			quarter_round(15, 12, 13, 14);
		end
		for (int i = 0; i < 16; i++)
			ks_words[i] = mix_w[i] + seed[i];
		block_ctr = block_ctr + 64'd1;
	endfunction

	function automatic logic [7:0] next_cipher_byte(logic [7:0] data, logic last);
		logic [7:0] ks_byte;
		if (!ks_ready) begin
			refill_keystream();
			ks_ready = 1'b1;
			ks_pos   = 6'd0;
		end
		ks_byte = 8'(ks_words[ks_pos[5:2]] >> (8 * ks_pos[1:0]));
		ks_pos  = ks_pos + 6'd1;
		if (ks_pos == 6'd0)
			ks_ready = 1'b0;
		// end of message drops the rest of the block
		if (last) begin
			ks_ready = 1'b0;
			ks_pos   = 6'd0;
		end
		return data ^ ks_byte;
	endfunction

	function automatic logic [63:0] pick_reg_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_beat(logic [7:0] data, logic last);
		plain_beats.push_back('{data: data, last: last});
	endtask

	task automatic queue_message(int len, bit closed);
		for (int i = 0; i < len; i++)
			queue_beat(8'($urandom), closed && (i == len - 1));
	endtask

	// Everything sent and every predicted byte back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (plain_beats.size() != 0 || s_tvalid || cipher_bytes_due.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KEY_PART_0: key_reg[0] = val;
			REG_KEY_PART_1: key_reg[1] = val;
			REG_KEY_PART_2: key_reg[2] = val;
			REG_KEY_PART_3: key_reg[3] = val;
			REG_NONCE: begin
				// counter restarts and the buffered block is dropped
				nonce_reg = val;
				block_ctr = '0;
				ks_ready  = 1'b0;
				ks_pos    = 6'd0;
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Source: one beat per queue entry, random gap after each
	always @(posedge clk or negedge arst_n) begin : source_side
		plain_beat_t beat;
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			s_tlast   <= 1'b0;
			send_wait <= '0;
		end else begin
			if (s_tvalid && s_tready)
				cipher_bytes_due.push_back(next_cipher_byte(s_tdata, s_tlast));
			if (!s_tvalid || s_tready) begin
				if (send_wait != 4'd0) begin
					s_tvalid  <= 1'b0;
					send_wait <= send_wait - 4'd1;
				end else if (plain_beats.size() != 0) begin
					beat = plain_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= beat.data;
					s_tlast  <= beat.last;
					if ($urandom_range(0, 23) == 0)
						send_calm = !send_calm;
					send_wait <= send_calm ? 4'd0 : 4'($urandom_range(0, 15));
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink: check each output beat, then stall a random number of cycles
	always @(posedge clk or negedge arst_n) begin : sink_side
		logic [3:0] hold;
		logic [7:0] want;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			recv_wait <= '0;
		end else if (m_tvalid && m_tready) begin
			if (cipher_bytes_due.size() == 0) begin
				$error("out_byte: expected none, actual %02h", m_tdata);
				fault_count++;
			end else begin
				want = cipher_bytes_due.pop_front();
				if (m_tdata !== want) begin
					$error("out_byte: expected %02h, actual %02h", want, m_tdata);
					fault_count++;
				end
			end
			if ($urandom_range(0, 23) == 0)
				recv_calm = !recv_calm;
			hold = recv_calm ? 4'd0 : 4'($urandom_range(0, 15));
			recv_wait <= hold;
			m_tready  <= (hold == 4'd0);
		end else if (recv_wait != 4'd0) begin
			recv_wait <= recv_wait - 4'd1;
			m_tready  <= (recv_wait == 4'd1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin : stimulus
		int random_beats;
		int phase_end;
		int len;
		bit closed;
		for (int i = 0; i < 4; i++)
			key_reg[i] = '0;
		nonce_reg = '0;
		block_ctr = '0;
		ks_pos    = 6'd0;
		ks_ready  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero key, zero nonce
		queue_beat(8'h00, 1'b0);
		queue_beat(8'hff, 1'b0);
		queue_beat(8'h5a, 1'b1);
		wait_idle();

		// All-ones key and nonce; indexes past the nonce do nothing
		for (int idx = REG_KEY_PART_0; idx <= REG_NONCE; idx++)
			write_reg(CFG_IDX_W'(idx), '1);
		for (int idx = REG_NONCE + 1; idx < (1 << CFG_IDX_W); idx++)
			write_reg(CFG_IDX_W'(idx), {$urandom, $urandom});
		queue_beat(8'ha5, 1'b0);
		queue_beat(8'h00, 1'b0);
		queue_beat(8'hff, 1'b1);
		// open message: leaves a block buffered
		queue_beat(8'h3c, 1'b0);
		queue_beat(8'hc3, 1'b0);
		wait_idle();

		// Key change keeps the buffered block; the open message ends on it, later messages use the new key
		write_reg(REG_KEY_PART_0, 64'h0123_4567_89ab_cdef);
		queue_beat(8'h81, 1'b0);
		queue_beat(8'h7e, 1'b1);
		queue_beat(8'hff, 1'b1);
		queue_beat(8'h11, 1'b0);
		queue_beat(8'hee, 1'b0);
		wait_idle();

		// Nonce change drops the buffered block and restarts the counter
		write_reg(REG_NONCE, '0);
		queue_beat(8'h00, 1'b1);
		queue_beat(8'haa, 1'b0);
		queue_beat(8'h55, 1'b1);
		wait_idle();

		// Random phases: new settings, then messages of mixed length
		random_beats = 0;
		while (random_beats < 450) begin
			for (int idx = 0; idx < (1 << CFG_IDX_W); idx++)
				if ($urandom_range(0, 1) == 1)
					write_reg(CFG_IDX_W'(idx), pick_reg_value());
			phase_end = random_beats + $urandom_range(50, 100);
			while (random_beats < phase_end) begin
				case ($urandom_range(0, 9))
					0: len = $urandom_range(60, 140);
					1: len = 64;
					2, 3: len = $urandom_range(17, 70);
					default: len = $urandom_range(1, 16);
				endcase
				closed = ($urandom_range(0, 9) != 0);
				queue_message(len, closed);
				random_beats += len;
			end
			wait_idle();
		end

		// anything arriving now is an unexpected beat
		repeat (250) @(posedge clk);
		if (fault_count == 0)
			$display("salsa20_stream_cipher verification clean");
		else
			$display("salsa20_stream_cipher verification failed");
		$finish;
	end

	initial begin : watchdog
		#1_000_000;
		$display("salsa20_stream_cipher verification failed");
		$finish;
	end

endmodule
